// File: src/cbs_pkg.sv
// Package for the Croston backcast seed unit: payload structs, status codes,
// controller/datapath command and status structs. No dependencies.
package cbs_pkg;

  typedef struct packed {
    logic signed [31:0] demand;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [30:0] level_seed;
    logic [24:0] interval_seed;
    logic [16:0] demand_probability;
    logic [1:0]  status;
  } out_item_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_NO_DEM   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [15:0] ALPHA_RESET = 16'd3277;
  localparam logic [16:0] ONE_Q15     = 17'd32768;
  localparam logic [16:0] PROB_ONE    = 17'd65536;
  localparam logic [24:0] INTERVAL_MAX = 25'h1FFFFFF;

  // controller to datapath
  typedef struct packed {
    logic load;        // store accepted sample, update sums
    logic seed_start;  // clear and start seed divisions
    logic div_step;    // one restoring step on both dividers
    logic pass_first;  // set read address to newest sample
    logic pass_read;   // issue read and advance address
    logic pass_upd;    // apply blend for the registered sample
    logic prob_start;  // load probability divider
    logic finish;      // latch result, clear window
  } cbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic few;
    logic no_pos;
  } cbs_stat_t;

endpackage

// File: src/cbs_datapath.sv
// Datapath of the Croston backcast seed unit: sample memory, window sums,
// shared bit-serial dividers and the blend multipliers. Uses cbs_pkg.
module cbs_datapath #(
  parameter int WINDOW_MAX = 256,
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbs_pkg::in_item_t   item,
  input  logic [15:0]         alpha,
  input  cbs_pkg::cbs_cmd_t   cmd,
  output cbs_pkg::cbs_stat_t  stat,
  output logic [CW-1:0]       count,
  output cbs_pkg::out_item_t  result
);

  logic signed [31:0] mem [WINDOW_MAX];
  logic signed [31:0] rd_r;
  logic [CW-1:0]      cnt_r, pos_r, gap_r, rd_addr_r;
  logic [39:0]        sum_r;
  logic               ovf_r;
  logic [31:0]        lvl_r;
  logic [31:0]        itv_r;
  // dividers: quotient in low part of shift registers
  logic [47:0]        dq_r, dq2_r;      // dividends shifting out
  logic [47:0]        rm_r, rm2_r;      // remainders
  logic [31:0]        dv_r;             // probability divisor
  logic               pmode_r;
  logic [16:0]        q15a;
  cbs_pkg::out_item_t res_r;

  assign count = cnt_r;
  assign stat.few = cnt_r < CW'(2);
  assign stat.no_pos = pos_r == '0;
  assign result = res_r;
  assign q15a = ({1'b0, alpha} > cbs_pkg::ONE_Q15) ? cbs_pkg::ONE_Q15 : {1'b0, alpha};

  // memory
  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r < CW'(WINDOW_MAX)) mem[cnt_r[AW-1:0]] <= item.demand;
    if (cmd.pass_read) rd_r <= mem[rd_addr_r[AW-1:0]];
  end

  // blend products: two multipliers per path (level and interval)
  logic [16:0] na;
  logic [49:0] lv_new, iv_new;
  logic [CW-1:0] gap_n;
  assign na = cbs_pkg::ONE_Q15 - q15a;
  assign gap_n = gap_r + CW'(1);
  assign lv_new = 50'(q15a) * 50'(unsigned'(rd_r)) + 50'(na) * 50'(lvl_r) + 50'd16384;
  assign iv_new = 50'(q15a) * 50'({gap_n, 16'd0}) + 50'(na) * 50'(itv_r) + 50'd16384;

  // restoring division step helpers
  logic [48:0] t1, t2;
  assign t1 = {rm_r, dq_r[47]} - 49'(pos_r);
  assign t2 = pmode_r ? ({rm2_r, dq2_r[47]} - 49'(dv_r))
                      : ({rm2_r, dq2_r[47]} - 49'(pos_r));

  logic [31:0] lq, iq;
  logic [33:0] pq;
  assign lq = dq_r[31:0];
  assign iq = dq2_r[31:0];
  assign pq = {1'b0, dq2_r[32:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; pos_r <= '0; sum_r <= '0; ovf_r <= 1'b0;
    end else if (cmd.finish) begin
      cnt_r <= '0; pos_r <= '0; sum_r <= '0; ovf_r <= 1'b0;
    end else if (cmd.load) begin
      if (cnt_r < CW'(WINDOW_MAX)) begin
        cnt_r <= cnt_r + CW'(1);
        if (item.demand > 0) begin
          pos_r <= pos_r + CW'(1);
          sum_r <= sum_r + 40'(unsigned'(item.demand));
        end
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      pmode_r <= 1'b0;
      rm_r <= '0; rm2_r <= '0;
      dq_r <= 48'(sum_r);
      dq2_r <= 48'({cnt_r, 16'd0});
    end else if (cmd.div_step) begin
      if (!t1[48]) begin rm_r <= t1[47:0]; dq_r <= {dq_r[46:0], 1'b1}; end
      else begin rm_r <= {rm_r[46:0], dq_r[47]}; dq_r <= {dq_r[46:0], 1'b0}; end
      if (!t2[48]) begin rm2_r <= t2[47:0]; dq2_r <= {dq2_r[46:0], 1'b1}; end
      else begin rm2_r <= {rm2_r[46:0], dq2_r[47]}; dq2_r <= {dq2_r[46:0], 1'b0}; end
    end else if (cmd.prob_start) begin
      pmode_r <= 1'b1;
      rm2_r <= '0;
      dv_r <= itv_r;
      dq2_r <= 48'h1_0000_0000 + 48'(itv_r >> 1);
    end
    if (cmd.pass_first) begin
      lvl_r <= lq;
      itv_r <= iq;
      gap_r <= '0;
      rd_addr_r <= cnt_r - CW'(1);
    end else begin
      if (cmd.pass_read) rd_addr_r <= rd_addr_r - CW'(1);
      if (cmd.pass_upd) begin
        if (rd_r > 0) begin
          lvl_r <= lv_new[46:15];
          itv_r <= iv_new[46:15];
          gap_r <= '0;
        end else begin
          gap_r <= gap_n;
        end
      end
    end
    if (cmd.finish) begin
      if (stat.few) begin
        res_r <= '{31'd0, 25'd0, 17'd0, cbs_pkg::ST_FEW};
      end else if (stat.no_pos) begin
        res_r <= '{31'd0, 25'd0, 17'd0, cbs_pkg::ST_NO_DEM};
      end else begin
        res_r.level_seed <= lvl_r[30:0];
        res_r.interval_seed <= (itv_r > 32'(cbs_pkg::INTERVAL_MAX)) ?
                               cbs_pkg::INTERVAL_MAX : itv_r[24:0];
        res_r.demand_probability <= (itv_r == '0 || pq > 34'(cbs_pkg::PROB_ONE)) ?
                                    cbs_pkg::PROB_ONE : pq[16:0];
        res_r.status <= ovf_r ? cbs_pkg::ST_OVERFLOW : cbs_pkg::ST_OK;
      end
    end
  end

endmodule

// File: src/cbs_ctrl.sv
// Controller of the Croston backcast seed unit: sequences load, seed
// division, backward pass, probability division and output. Uses cbs_pkg.
module cbs_ctrl #(
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_last,
  input  logic               out_stall,
  output logic               out_valid,
  input  cbs_pkg::cbs_stat_t stat,
  input  logic [CW-1:0]      count,
  output cbs_pkg::cbs_cmd_t  cmd
);

  typedef enum logic [2:0] {S_LOAD, S_SEED, S_PASS, S_PDIV, S_DONE, S_OUT} state_t;
  state_t   state_r;
  logic [5:0] n_r;
  logic [CW-1:0] left_r;
  logic upd_r;
  logic acc;

  assign in_stall = state_r != S_LOAD;
  assign acc = in_valid && state_r == S_LOAD;

  always_comb begin
    cmd = '0;
    cmd.load = acc;
    unique case (state_r)
      S_LOAD: ;
      // load dividers once the closing sample has reached the sums
      S_SEED: begin
        cmd.seed_start = n_r == 6'd0;
        cmd.div_step = n_r != 6'd0 && n_r != 6'd49;
        cmd.pass_first = n_r == 6'd49;
      end
      S_PASS: begin
        cmd.pass_read = left_r != '0;
        cmd.pass_upd = upd_r;
        cmd.prob_start = left_r == '0 && !upd_r;
      end
      S_PDIV: cmd.div_step = 1'b1;
      S_DONE: cmd.finish = 1'b1;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; n_r <= '0; left_r <= '0; upd_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: if (acc && in_last) begin
          n_r <= '0;
          state_r <= S_SEED;
        end
        S_SEED: begin
          n_r <= n_r + 6'd1;
          if (n_r == 6'd49) begin
            if (stat.few || stat.no_pos) state_r <= S_DONE;
            else begin state_r <= S_PASS; left_r <= count; upd_r <= 1'b0; end
          end
        end
        S_PASS: begin
          upd_r <= left_r != '0;
          if (left_r != '0) left_r <= left_r - CW'(1);
          if (left_r == '0 && !upd_r) begin state_r <= S_PDIV; n_r <= '0; end
        end
        S_PDIV: begin
          n_r <= n_r + 6'd1;
          if (n_r == 6'd47) state_r <= S_DONE;
        end
        S_DONE: begin state_r <= S_OUT; out_valid <= 1'b1; end
        S_OUT: if (!out_stall) begin out_valid <= 1'b0; state_r <= S_LOAD; end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

// File: src/croston_backcast_seed_unit.sv
// Croston backcast seed unit, top level.
// Channels: in_ (demand samples, last_sample closes a window), out_ (one
// result per closed window), cfg_ (alpha register write).
// Samples are accepted one per cycle while a window is open. After the
// closing sample the unit stalls its input while it loads the seed
// dividers, runs the seed division (one quotient bit per cycle), starts
// the pass, runs the backward smoothing pass over the N stored samples
// (one memory read per cycle), runs the probability division and
// registers the result. A window with too few samples or no positive
// demand skips the pass and the probability division.
// The result holds in the output register until the receiver drops
// out_stall; no new window is loaded until it is taken.
// Reset (rst_n low, synchronous) empties the window, sets alpha to 3277
// and drops out_valid. cfg_ready is always high.
module croston_backcast_seed_unit #(
  parameter int WINDOW_MAX = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [15:0]        alpha_r;
  cbs_pkg::cbs_cmd_t  cmd;
  cbs_pkg::cbs_stat_t stat;
  logic [CW-1:0]      count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) alpha_r <= cbs_pkg::ALPHA_RESET;
    else if (cfg_valid) alpha_r <= cfg_data;
  end

  cbs_ctrl #(.CW(CW)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last(in_data.last_sample),
    .out_stall, .out_valid, .stat, .count, .cmd
  );

  cbs_datapath #(.WINDOW_MAX(WINDOW_MAX), .AW(AW), .CW(CW)) u_dp (
    .clk, .rst_n, .item(in_data), .alpha(alpha_r), .cmd, .stat, .count,
    .result(out_data)
  );

endmodule

// File: tb/croston_backcast_seed_unit_test.sv
// Testbench for croston_backcast_seed_unit: demand windows with random content,
// alpha writes between phases, a seed predictor and a result scoreboard.
// Depends on cbs_pkg and the unit itself.
module croston_backcast_seed_unit_test;

  localparam int WIN_DEPTH = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cbs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cbs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  croston_backcast_seed_unit #(.WINDOW_MAX(WIN_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cbs_pkg::in_item_t samples_pending[$];
  cbs_pkg::out_item_t seeds_expected[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_sender = 1'b0;

  // seed predictor state
  logic [15:0] alpha_reg = cbs_pkg::ALPHA_RESET;
  logic signed [31:0] win_mem[WIN_DEPTH];
  int win_count = 0;
  int pos_count = 0;
  longint unsigned pos_sum = 0;
  bit dropped = 1'b0;

  function automatic longint unsigned blend(longint unsigned a, longint unsigned fresh,
                                            longint unsigned old);
    return (a * fresh + (64'd32768 - a) * old + 64'd16384) >> 15;
  endfunction

  task automatic absorb_sample(input cbs_pkg::in_item_t it);
    cbs_pkg::out_item_t res;
    longint unsigned a, lvl, ivl, gap, prob;
    logic signed [31:0] v;
    if (win_count < WIN_DEPTH) begin
      win_mem[win_count] = it.demand;
      win_count++;
      if (it.demand > 0) begin
        pos_sum += longint'(it.demand);
        pos_count++;
      end
    end else begin
      dropped = 1'b1;
    end
    if (!it.last_sample) return;
    res = '0;
    if (win_count < 2) begin
      res.status = cbs_pkg::ST_FEW;
    end else if (pos_count == 0) begin
      res.status = cbs_pkg::ST_NO_DEM;
    end else begin
      res.status = dropped ? cbs_pkg::ST_OVERFLOW : cbs_pkg::ST_OK;
      a = (alpha_reg > 16'd32768) ? 64'd32768 : 64'(alpha_reg);
      lvl = pos_sum / pos_count;
      ivl = (64'(win_count) << 16) / pos_count;
      gap = 0;
      for (int i = win_count - 1; i >= 0; i--) begin
        v = win_mem[i];
        gap++;
        if (v > 0) begin
          lvl = blend(a, 64'(v), lvl);
          ivl = blend(a, gap << 16, ivl);
          gap = 0;
        end
      end
      if (ivl == 0) prob = 65536;
      else begin
        prob = ((64'd1 << 32) + (ivl >> 1)) / ivl;
        if (prob > 65536) prob = 65536;
      end
      if (ivl > 64'h1FFFFFF) ivl = 64'h1FFFFFF;
      res.level_seed = lvl[30:0];
      res.interval_seed = ivl[24:0];
      res.demand_probability = prob[16:0];
    end
    seeds_expected.push_back(res);
    win_count = 0;
    pos_count = 0;
    pos_sum = 0;
    dropped = 1'b0;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 34);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_sample(in_data);
      if (!in_valid || !in_stall) begin
        if (samples_pending.size() > 0 && !hold_sender && !idle_now()) begin
          in_valid <= 1'b1;
          in_data <= samples_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cbs_pkg::out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (seeds_expected.size() == 0) begin
        $display("unexpected result transaction at cycle %0d", cycles);
        errors++;
      end else begin
        want = seeds_expected.pop_front();
        if (out_data.level_seed !== want.level_seed)
          report("level_seed", out_data.level_seed, want.level_seed);
        if (out_data.interval_seed !== want.interval_seed)
          report("interval_seed", out_data.interval_seed, want.interval_seed);
        if (out_data.demand_probability !== want.demand_probability)
          report("demand_probability", out_data.demand_probability,
                 want.demand_probability);
        if (out_data.status !== want.status)
          report("status", out_data.status, want.status);
      end
    end
    out_stall <= rst_n && idle_now();
  end

  function automatic logic signed [31:0] pick_demand();
    case ($urandom_range(0, 11))
      0: return 32'sd0;
      1: return -$signed(32'($urandom_range(1, 1000000)));
      2: return $signed($urandom());
      3: return 32'sh7FFFFFFF;
      4: return $signed({1'b0, 31'($urandom())});
      default: return $signed(32'($urandom_range(1, 200000)));
    endcase
  endfunction

  task automatic add_sample(input logic signed [31:0] d, input bit last);
    cbs_pkg::in_item_t it;
    it.demand = d;
    it.last_sample = last;
    samples_pending.push_back(it);
  endtask

  task automatic add_window(input int len);
    for (int i = 0; i < len; i++) add_sample(pick_demand(), i == len - 1);
  endtask

  task automatic settle();
    wait (samples_pending.size() == 0 && seeds_expected.size() == 0 && !in_valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    alpha_reg = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] alphas[7];
    int budget;
    int len;
    alphas = '{16'd3277, 16'd1, 16'd32768, 16'd0, 16'd65535, 16'd16384, 16'd200};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone sample, no demand, extremes, spread out demand
    add_sample(32'sd500, 1'b1);
    add_sample(-32'sd1, 1'b0); add_sample(32'sd0, 1'b0);
    add_sample(32'sh80000000, 1'b1);
    add_sample(32'sh7FFFFFFF, 1'b0); add_sample(32'sh7FFFFFFF, 1'b1);
    add_sample(32'sd1, 1'b0); add_sample(32'sh80000000, 1'b0);
    add_sample(32'sd0, 1'b0); add_sample(32'sd256, 1'b1);
    add_sample(32'sd0, 1'b0); add_sample(32'sd0, 1'b0); add_sample(32'sd0, 1'b0);
    add_sample(32'sd1000, 1'b1);
    add_sample(32'sd0, 1'b1);
    add_sample(32'sd300, 1'b0); add_sample(32'sd700, 1'b0);
    add_sample(32'sd0, 1'b0); add_sample(32'sd900, 1'b1);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      write_alpha(alphas[ph]);
      quiet = (ph == 2);
      budget = 270;
      if (ph == 4) begin
        // overflowing window: samples past the store are dropped
        add_window(WIN_DEPTH + 5);
        budget -= WIN_DEPTH + 5;
      end
      if (ph == 6) begin
        add_window(WIN_DEPTH);
        budget -= WIN_DEPTH;
      end
      while (budget > 0) begin
        case ($urandom_range(0, 9))
          0: len = 1;
          1: len = $urandom_range(20, 60);
          default: len = $urandom_range(2, 12);
        endcase
        add_window(len);
        budget -= len;
        if (ph == 1 && samples_pending.size() > 130 && !hold_sender) begin
          // pause the sender until every pending seed has come back
          hold_sender = 1'b1;
          wait (seeds_expected.size() == 0 && !in_valid);
          hold_sender = 1'b0;
        end
      end
      settle();
    end

    if (seeds_expected.size() == 0 && errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
src/cbs_pkg.sv
src/cbs_datapath.sv
src/cbs_ctrl.sv
src/croston_backcast_seed_unit.sv
tb/croston_backcast_seed_unit_test.sv
